@@ hw/rtl/hct_pkg.sv @@
// Shared types and constants for the hashed counter table.
// Used by the sequencer and the top level; no dependencies.
package hct_pkg;

    // Slot count; must be a power of two (the home slot is the key's low bits).
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 64;
    localparam int CNT_W         = 64;
    localparam int STATUS_W      = 2;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_KEY = 2'd2;

    typedef enum logic [1:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_PROBE
    } seq_state_t;

    typedef struct packed {
        logic in_valid;
        logic key_zero;
        logic key_match;
        logic slot_empty;
        logic last_probe;
        logic out_free;
        logic clear_last;
    } probe_stat_t;

    typedef struct packed {
        logic clearing;
        logic ready;
        logic accept;
        logic advance;
        logic finish;
    } seq_ctl_t;

endpackage

@@ hw/rtl/hashed_counter_table.sv @@
// Each request probes from 1 up to 256 slots, starting at its home slot and wrapping.
// Only one request is handled at a time; all probes share the single read port of the key/count memories.
// A new request is taken the cycle after the previous result is registered.
// Reset: asynchronous; a clearing pass then zeroes every slot of both stores, in_stall held high.
// Top level of the hashed counter table; instantiates hct_seq and hct_ram.
// Depends on hct_pkg.
module hashed_counter_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [hct_pkg::KEY_W-1:0]           lookup_key,
    input  logic signed [hct_pkg::CNT_W-1:0]    delta,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [hct_pkg::CNT_W-1:0]    total,
    output logic [hct_pkg::STATUS_W-1:0]        status
);
    import hct_pkg::*;

    probe_stat_t stat;
    seq_ctl_t    ctl;

    logic                op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [CNT_W-1:0]    delta_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic [IDX_W-1:0]    addr_inc;
    logic [IDX_W-1:0]    probe_cnt_reg;
    logic [IDX_W-1:0]    clr_addr_reg;

    logic                out_valid_reg;
    logic [CNT_W-1:0]    total_reg;
    logic [STATUS_W-1:0] status_reg;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [KEY_W-1:0]    wr_key;
    logic [CNT_W-1:0]    wr_cnt;
    logic [KEY_W-1:0]    key_rd;
    logic [CNT_W-1:0]    cnt_rd;

    logic                place_ok;
    logic [CNT_W-1:0]    new_total;
    logic [CNT_W-1:0]    result_total;
    logic [STATUS_W-1:0] result_status;

    hct_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    hct_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_key),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (key_rd)
    );

    hct_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_cnt),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (cnt_rd)
    );

    // status into the sequencer
    assign stat.in_valid   = in_valid;
    assign stat.key_zero   = (key_reg == '0);
    assign stat.key_match  = (key_rd == key_reg);
    assign stat.slot_empty = (key_rd == '0);
    assign stat.last_probe = (probe_cnt_reg == LAST_SLOT);
    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.clear_last = (clr_addr_reg == LAST_SLOT);

    assign in_stall = !ctl.ready;

    // probe address: home slot on intake, next slot (wrapping) while probing
    assign addr_inc = (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;
    assign rd_en    = ctl.accept || ctl.advance;
    assign rd_addr  = ctl.accept ? lookup_key[IDX_W-1:0] : addr_inc;

    // hit accumulates (add) or is read back (load), empty slot is claimed with a fresh counter
    assign place_ok = !stat.key_zero && (stat.key_match || stat.slot_empty);

    always_comb
    begin
        if (stat.key_match)
        begin
            new_total = (op_reg == OP_ADD) ? cnt_rd + delta_reg : cnt_rd;
        end
        else
        begin
            new_total = (op_reg == OP_ADD) ? delta_reg : '0;
        end
    end

    always_comb
    begin
        if (stat.key_zero)
        begin
            result_status = STATUS_ZERO_KEY;
            result_total  = '0;
        end
        else if (place_ok)
        begin
            result_status = STATUS_OK;
            result_total  = new_total;
        end
        else
        begin
            result_status = STATUS_FULL;
            result_total  = '0;
        end
    end

    assign wr_en   = ctl.clearing || (ctl.finish && place_ok);
    assign wr_addr = ctl.clearing ? clr_addr_reg : addr_reg;
    assign wr_key  = ctl.clearing ? '0 : key_reg;
    assign wr_cnt  = ctl.clearing ? '0 : new_total;

    // request payload
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            op_reg    <= opcode;
            key_reg   <= lookup_key;
            delta_reg <= delta;
        end
    end

    // probe position and clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            probe_cnt_reg <= '0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            if (ctl.accept)
            begin
                addr_reg      <= lookup_key[IDX_W-1:0];
                probe_cnt_reg <= '0;
            end
            else if (ctl.advance)
            begin
                addr_reg      <= addr_inc;
                probe_cnt_reg <= probe_cnt_reg + 1'b1;
            end
            if (ctl.clearing)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            total_reg  <= result_total;
            status_reg <= result_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign total     = total_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("memory write overlaps a probe read");

    a_stall_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clearing |-> in_stall)
        else $error("request taken during clearing pass");

    a_fail_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> (total == '0))
        else $error("nonzero total on a failed request");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctl.finish))
        else $error("result appeared without a finished probe");
`endif

endmodule

@@ hw/rtl/hct_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hct_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/hct_seq.sv @@
// Probe sequencer: clearing pass after reset, request intake, probe loop.
// Depends on hct_pkg.
module hct_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hct_pkg::probe_stat_t stat,
    output hct_pkg::seq_ctl_t    ctl
);
    import hct_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;
    logic       probe_done;

    assign probe_done = stat.key_zero || stat.key_match || stat.slot_empty || stat.last_probe;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = SEQ_PROBE;
                end
            end
            SEQ_PROBE:
            begin
                if (probe_done && stat.out_free)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            SEQ_CLEAR:
            begin
                ctl.clearing = 1'b1;
            end
            SEQ_IDLE:
            begin
                ctl.ready  = 1'b1;
                ctl.accept = stat.in_valid;
            end
            SEQ_PROBE:
            begin
                ctl.advance = !probe_done;
                ctl.finish  = probe_done && stat.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule
